// ===== design/assert_macros.svh =====
// Assertion macros shared by the engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside of reset.
`define ALLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("engine assertion failed");

// Implication checked on every rising clock edge outside of reset.
`define ALLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("engine assertion failed");

`else

`define ALLE_ASSERT(lbl, clk, rst_n, prop)
`define ALLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/alle_pkg.sv =====
// Types and constants of the array linked list engine.
`timescale 1ns / 1ps

package alle_pkg;

  // Beat widths, whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // Input field widths.
  localparam int MODE_W  = 3;
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;

  // Output field widths.
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int NODE_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int OUT_USED_W = STATUS_W + DATA_W + NODE_W + COUNT_W;

  typedef enum logic [MODE_W-1:0] {
    MD_READ      = 3'd0,
    MD_OVERWRITE = 3'd1,
    MD_REMOVE    = 3'd2,
    MD_INSERT    = 3'd3,
    MD_FRONT     = 3'd4,
    MD_BACK      = 3'd5,
    MD_SEARCH    = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

// ===== design/array_linked_list_engine_core.sv =====
// Command engine for a doubly linked list kept in a fixed node store.
`timescale 1ns / 1ps
//
//  Channel  | Ports                         | Beat contents (lowest bit first)
//  ---------+-------------------------------+----------------------------------------
//  command  | in_tvalid/in_tready/in_tdata  | mode[2:0], position[6:3], value[38:7]
//  result   | out_tvalid/out_tready/out_tdata| status[1:0], data_out[33:2],
//           |                               | node_index[37:34], element_count[42:38]
//
//  After reset the link memory is swept once to build the free chain, with
//  in_tready low. One command is worked at a time, all of it paced by the
//  single registered read port of the link memory: read, overwrite, bad
//  position and full finish after the check of the addressed slot; add
//  front/back, insert after and remove then patch any neighbour link words,
//  each by a read and a write; search reads the list nodes in order from the head.
//  A finished result waits in the output register while the next command is
//  accepted; a stalled result only holds the engine once a second one is done.

module array_linked_list_engine_core #(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // mode, position, value, zero pad
  input  logic [alle_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, data_out, node_index, element_count, zero pad
  output logic [alle_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import alle_pkg::*;

  localparam int IW = $clog2(CAPACITY);       // slot index
  localparam int LW = $clog2(CAPACITY + 1);   // link, holds the null code
  localparam int PW = (LW > POS_W) ? LW : POS_W;
  localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;
  localparam logic [LW-1:0] NIL     = LW'(CAPACITY);
  localparam logic [PW-1:0] CAP_POS = PW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IX = IW'(CAPACITY - 1);

  typedef struct packed {
    logic          occ;
    logic [LW-1:0] prv;
    logic [LW-1:0] nxt;
  } link_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CHK, S_TAKE, S_PRD, S_PWR, S_SRCH, S_DONE
  } state_t;

  // Node store: link word per slot, element per slot.
  link_t                    link_mem [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] elem_mem [CAPACITY];

  link_t                    link_q;
  logic [ELEMENT_WIDTH-1:0] elem_q;
  logic [IW-1:0]            mem_ra;
  logic                     link_we, elem_we;
  logic [IW-1:0]            link_wa, elem_wa;
  link_t                    link_wd;
  logic [ELEMENT_WIDTH-1:0] elem_wd;

  state_t                   state_r, state_nxt;
  logic [IW-1:0]            init_idx_r, init_idx_nxt;
  logic [MODE_W-1:0]        mode_r, mode_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic [ELEMENT_WIDTH-1:0] val_r, val_nxt;
  logic [LW-1:0]            head_r, head_nxt;
  logic [LW-1:0]            tail_r, tail_nxt;
  logic [LW-1:0]            free_r, free_nxt;
  logic [LW-1:0]            count_r, count_nxt;
  logic [LW-1:0]            cur_r, cur_nxt;
  logic [LW-1:0]            nx_r, nx_nxt;
  // pending link patches: target, new value, patch next (1) or prev (0)
  logic [LW-1:0]            pa_tgt_r, pa_tgt_nxt, pa_val_r, pa_val_nxt;
  logic                     pa_fld_r, pa_fld_nxt;
  logic                     pb_vld_r, pb_vld_nxt;
  logic [LW-1:0]            pb_tgt_r, pb_tgt_nxt, pb_val_r, pb_val_nxt;
  logic                     pb_fld_r, pb_fld_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic [DATA_W-1:0]        res_data_r, res_data_nxt;
  logic [LW-1:0]            res_node_r, res_node_nxt;
  logic                     out_vld_r, out_vld_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [DATA_W-1:0]        out_data_r, out_data_nxt;
  logic [NODE_W-1:0]        out_node_r, out_node_nxt;
  logic [COUNT_W-1:0]       out_count_r, out_count_nxt;

  logic [MODE_W-1:0]        in_mode;
  logic [PW-1:0]            in_pos;
  logic [63:0]              in_val64;
  logic [63:0]              elem_q64;
  logic [DATA_W-1:0]        elem_q_data;
  logic [PW-1:0]            res_node_ext;
  logic [CW-1:0]            count_ext;
  logic                     pos_ok, full, prv_ok, nxt_ok, take_go;

  assign in_mode     = in_tdata[MODE_W-1:0];
  assign in_pos      = PW'(in_tdata[MODE_W+POS_W-1:MODE_W]);
  assign in_val64    = {32'd0, in_tdata[MODE_W+POS_W+VALUE_W-1:MODE_W+POS_W]};
  assign elem_q64    = 64'(elem_q);
  assign elem_q_data = elem_q64[DATA_W-1:0];
  assign res_node_ext = PW'(res_node_r);
  assign count_ext   = CW'(count_r);

  assign pos_ok = (pos_r < CAP_POS) && link_q.occ;
  assign full   = (count_r == NIL);
  assign prv_ok = (link_q.prv != NIL);
  assign nxt_ok = (link_q.nxt != NIL);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                       out_count_r, out_node_r, out_data_r, out_status_r};

  // Node store: one write and one registered read per memory per cycle.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (elem_we) begin
      elem_mem[elem_wa] <= elem_wd;
    end
    link_q <= link_mem[mem_ra];
    elem_q <= elem_mem[mem_ra];
  end

  always_comb begin
    state_nxt      = state_r;
    init_idx_nxt   = init_idx_r;
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    nx_nxt         = nx_r;
    pa_tgt_nxt     = pa_tgt_r;
    pa_val_nxt     = pa_val_r;
    pa_fld_nxt     = pa_fld_r;
    pb_vld_nxt     = pb_vld_r;
    pb_tgt_nxt     = pb_tgt_r;
    pb_val_nxt     = pb_val_r;
    pb_fld_nxt     = pb_fld_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_node_nxt   = res_node_r;
    // drop the held result once it is taken
    out_vld_nxt    = out_vld_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_node_nxt   = out_node_r;
    out_count_nxt  = out_count_r;
    mem_ra         = '0;
    link_we        = 1'b0;
    link_wa        = '0;
    link_wd        = link_q;
    elem_we        = 1'b0;
    elem_wa        = '0;
    elem_wd        = val_r;
    take_go        = 1'b0;

    unique case (state_r)
      // Build the free chain: slot i links to i+1, the last to null.
      S_INIT: begin
        link_we = 1'b1;
        link_wa = init_idx_r;
        link_wd = '{occ: 1'b0, prv: NIL, nxt: LW'(init_idx_r) + LW'(1)};
        init_idx_nxt = init_idx_r + IW'(1);
        if (init_idx_r == LAST_IX) begin
          state_nxt = S_IDLE;
        end
      end

      // Capture the command and start the first read.
      S_IDLE: begin
        mem_ra = in_pos[IW-1:0];
        if (in_tvalid) begin
          mode_nxt       = in_mode;
          pos_nxt        = in_pos;
          val_nxt        = in_val64[ELEMENT_WIDTH-1:0];
          res_status_nxt = ST_OK;
          res_data_nxt   = '0;
          res_node_nxt   = '0;
          pb_vld_nxt     = 1'b0;
          cur_nxt        = head_r;
          unique case (in_mode)
            MD_READ, MD_OVERWRITE, MD_REMOVE, MD_INSERT: begin
              state_nxt = S_CHK;
            end
            MD_FRONT, MD_BACK: begin
              mem_ra    = free_r[IW-1:0];
              state_nxt = S_CHK;
            end
            MD_SEARCH: begin
              mem_ra = head_r[IW-1:0];
              if (head_r == NIL) begin
                res_status_nxt = ST_NOTFOUND;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Link word and element of the addressed slot are in hand.
      S_CHK: begin
        state_nxt = S_DONE;
        unique case (mode_r)
          MD_FRONT, MD_BACK: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              take_go = 1'b1;
            end
          end
          default: begin
            if (!pos_ok) begin
              res_status_nxt = ST_BADPOS;
            end else begin
              unique case (mode_r)
                MD_READ: begin
                  res_data_nxt = elem_q_data;
                  res_node_nxt = LW'(pos_r);
                end
                MD_OVERWRITE: begin
                  res_data_nxt = elem_q_data;
                  res_node_nxt = LW'(pos_r);
                  elem_we      = 1'b1;
                  elem_wa      = pos_r[IW-1:0];
                end
                MD_REMOVE: begin
                  res_data_nxt = elem_q_data;
                  res_node_nxt = LW'(pos_r);
                  // return the slot to the free chain
                  link_we   = 1'b1;
                  link_wa   = pos_r[IW-1:0];
                  link_wd   = '{occ: 1'b0, prv: link_q.prv, nxt: free_r};
                  free_nxt  = LW'(pos_r);
                  count_nxt = count_r - LW'(1);
                  if (!prv_ok) begin
                    head_nxt = link_q.nxt;
                  end
                  if (!nxt_ok) begin
                    tail_nxt = link_q.prv;
                  end
                  // unlink from neighbors: prev.next = next, next.prev = prev
                  if (prv_ok) begin
                    pa_tgt_nxt = link_q.prv;
                    pa_val_nxt = link_q.nxt;
                    pa_fld_nxt = 1'b1;
                    pb_vld_nxt = nxt_ok;
                    pb_tgt_nxt = link_q.nxt;
                    pb_val_nxt = link_q.prv;
                    pb_fld_nxt = 1'b0;
                    state_nxt  = S_PRD;
                  end else if (nxt_ok) begin
                    pa_tgt_nxt = link_q.nxt;
                    pa_val_nxt = link_q.prv;
                    pa_fld_nxt = 1'b0;
                    state_nxt  = S_PRD;
                  end
                end
                default: begin
                  // insert after: position checked first, then space
                  if (full) begin
                    res_status_nxt = ST_FULL;
                  end else begin
                    link_we   = 1'b1;
                    link_wa   = pos_r[IW-1:0];
                    link_wd   = '{occ: link_q.occ, prv: link_q.prv, nxt: free_r};
                    nx_nxt    = link_q.nxt;
                    mem_ra    = free_r[IW-1:0];
                    state_nxt = S_TAKE;
                  end
                end
              endcase
            end
          end
        endcase
      end

      S_TAKE: begin
        take_go = 1'b1;
      end

      // Read the patch target.
      S_PRD: begin
        mem_ra    = pa_tgt_r[IW-1:0];
        state_nxt = S_PWR;
      end

      // Write it back with one link replaced.
      S_PWR: begin
        link_we = 1'b1;
        link_wa = pa_tgt_r[IW-1:0];
        link_wd = link_q;
        if (pa_fld_r) begin
          link_wd.nxt = pa_val_r;
        end else begin
          link_wd.prv = pa_val_r;
        end
        if (pb_vld_r) begin
          pa_tgt_nxt = pb_tgt_r;
          pa_val_nxt = pb_val_r;
          pa_fld_nxt = pb_fld_r;
          pb_vld_nxt = 1'b0;
          state_nxt  = S_PRD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // One node per cycle from the head.
      S_SRCH: begin
        if (elem_q == val_r) begin
          res_status_nxt = ST_OK;
          res_node_nxt   = cur_r;
          state_nxt      = S_DONE;
        end else if (!nxt_ok) begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end else begin
          mem_ra  = link_q.nxt[IW-1:0];
          cur_nxt = link_q.nxt;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_node_nxt   = res_node_ext[NODE_W-1:0];
          out_count_nxt  = count_ext[COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
    endcase

    // Allocate the free head: link_q holds its link word here.
    if (take_go) begin
      link_we        = 1'b1;
      link_wa        = free_r[IW-1:0];
      elem_we        = 1'b1;
      elem_wa        = free_r[IW-1:0];
      free_nxt       = link_q.nxt;
      count_nxt      = count_r + LW'(1);
      res_node_nxt   = free_r;
      pb_vld_nxt     = 1'b0;
      state_nxt      = S_DONE;
      unique case (mode_r)
        MD_INSERT: begin
          link_wd = '{occ: 1'b1, prv: LW'(pos_r), nxt: nx_r};
          if (nx_r != NIL) begin
            pa_tgt_nxt = nx_r;
            pa_val_nxt = free_r;
            pa_fld_nxt = 1'b0;
            state_nxt  = S_PRD;
          end else begin
            tail_nxt = free_r;
          end
        end
        MD_FRONT: begin
          link_wd  = '{occ: 1'b1, prv: NIL, nxt: head_r};
          head_nxt = free_r;
          if (head_r != NIL) begin
            pa_tgt_nxt = head_r;
            pa_val_nxt = free_r;
            pa_fld_nxt = 1'b0;
            state_nxt  = S_PRD;
          end else begin
            tail_nxt = free_r;
          end
        end
        default: begin
          link_wd  = '{occ: 1'b1, prv: tail_r, nxt: NIL};
          tail_nxt = free_r;
          if (tail_r != NIL) begin
            pa_tgt_nxt = tail_r;
            pa_val_nxt = free_r;
            pa_fld_nxt = 1'b1;
            state_nxt  = S_PRD;
          end else begin
            head_nxt = free_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      init_idx_r <= '0;
      head_r     <= NIL;
      tail_r     <= NIL;
      free_r     <= '0;
      count_r    <= '0;
      pb_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_idx_r   <= init_idx_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      free_r       <= free_nxt;
      count_r      <= count_nxt;
      pb_vld_r     <= pb_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      mode_r       <= mode_nxt;
      pos_r        <= pos_nxt;
      val_r        <= val_nxt;
      cur_r        <= cur_nxt;
      nx_r         <= nx_nxt;
      pa_tgt_r     <= pa_tgt_nxt;
      pa_val_r     <= pa_val_nxt;
      pa_fld_r     <= pa_fld_nxt;
      pb_tgt_r     <= pb_tgt_nxt;
      pb_val_r     <= pb_val_nxt;
      pb_fld_r     <= pb_fld_nxt;
      res_status_r <= res_status_nxt;
      res_data_r   <= res_data_nxt;
      res_node_r   <= res_node_nxt;
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_node_r   <= out_node_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

`include "assert_macros.svh"

  `ALLE_ASSERT(a_count_bound, clk, rst_n, count_r <= NIL)
  `ALLE_ASSERT(a_free_vs_count, clk, rst_n, (free_r == NIL) == (count_r == NIL))
  `ALLE_ASSERT(a_ends_vs_count, clk, rst_n, (head_r == NIL) == (count_r == '0))
  `ALLE_ASSERT(a_head_tail_null, clk, rst_n, (head_r == NIL) == (tail_r == NIL))
  `ALLE_ASSERT_IMPL(a_alloc_same_slot, clk, rst_n, link_we && elem_we, link_wa == elem_wa)

endmodule
